@@ src/assert_macros.svh @@
// Assertion macros shared by the int_set_table RTL.
// Concurrent checks on a named clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the given clock, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on the block clock clk_i and reset rst_ni.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ src/ist_pkg.sv @@
`timescale 1ns / 1ps
// Package for the int_set_table block: beat types, operation and status codes,
// and the token that walks the cell row. No dependencies.
package ist_pkg;

  localparam int unsigned OCC_W = 7;

  // Operation codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_TEST   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EXISTS = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [OCC_W-1:0] occupancy;
    logic             empty_res;
    logic [1:0]       status;
  } out_item_t;

  // Token handed from cell to cell: one per operation in flight.
  typedef struct packed {
    logic       vld;    // token present in this cell
    logic       shift;  // remove in progress: pull entries down from the next cell
    logic       fin;    // outcome settled, pass through unchanged
    logic       found;
    logic [1:0] status;
  } tok_t;

endpackage

@@ src/ist_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of the set row: holds an entry and its valid flag and acts
// on the token as it passes. Depends on ist_pkg.
module ist_cell import ist_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  tok_t        tok_i,
  input  logic        next_valid_i,
  input  logic [31:0] next_entry_i,
  output tok_t        tok_o,
  output logic        valid_o,
  output logic [31:0] entry_o
);

  tok_t        tok_q, tok_d;
  logic        valid_q, valid_d;
  logic [31:0] entry_q, entry_d;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    entry_d = entry_q;
    if (tok_i.vld && !tok_i.fin) begin
      if (tok_i.shift) begin
        // pull the next entry down; stop at the end of the set
        entry_d = next_entry_i;
        valid_d = next_valid_i;
        if (!next_valid_i) begin
          tok_d.fin = 1'b1;
        end
      end else if (valid_q) begin
        if (entry_q == key_i) begin
          tok_d.found = 1'b1;
          case (func_i)
            FUNC_ADD: begin
              tok_d.fin    = 1'b1;
              tok_d.status = ST_EXISTS;
            end
            FUNC_REMOVE: begin
              entry_d = next_entry_i;
              valid_d = next_valid_i;
              if (next_valid_i) begin
                tok_d.shift = 1'b1;
              end else begin
                tok_d.fin = 1'b1;
              end
            end
            default: begin
              tok_d.fin = 1'b1;
            end
          endcase
        end
      end else begin
        // first free cell: the value is not in the set
        tok_d.fin = 1'b1;
        case (func_i)
          FUNC_ADD: begin
            entry_d = key_i;
            valid_d = 1'b1;
          end
          FUNC_REMOVE: begin
            tok_d.status = ST_ABSENT;
          end
          default: begin
            tok_d.status = ST_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      tok_q   <= tok_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      entry_q <= entry_d;
    end
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

@@ src/int_set_table.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Set of distinct 32-bit integers held packed in a row of CAPACITY cells. Each
// accepted beat injects a token at cell 0 that moves one cell per clock unless
// the row is frozen; a cell compares its entry with the value, a free cell
// takes an added value, and a remove pulls every later entry one cell down.
// The result beat is registered when the token leaves the last cell, and the
// next beat is taken no sooner than that; only one item is in the row at once.
// A stalled result beat freezes the row once the next token reaches its end,
// until the beat is taken. Depends on ist_pkg, ist_cell and assert_macros.svh.
module int_set_table import ist_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  in_item_t         item_q;
  logic             busy_q;
  tok_t             tok0_q, tok0_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_item_t        out_q, out_d;

  tok_t        tok_w   [CAPACITY+1];
  logic        valid_w [CAPACITY+1];
  logic [31:0] entry_w [CAPACITY+1];

  logic                   accept;
  logic                   adv;
  logic                   exit_tok;
  tok_t                   last_tok;
  logic [1:0]             fin_status;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign last_tok   = tok_w[CAPACITY];
  // hold the whole row while the result register is still occupied
  assign adv        = !(last_tok.vld && out_valid_q && !out_ready_i);
  assign exit_tok   = last_tok.vld && adv;

  assign tok_w[0]          = tok0_q;
  assign valid_w[CAPACITY] = 1'b0;
  assign entry_w[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ist_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .func_i       (item_q.func),
      .key_i        (32'(item_q.value)),
      .tok_i        (tok_w[g]),
      .next_valid_i (valid_w[g+1]),
      .next_entry_i (entry_w[g+1]),
      .tok_o        (tok_w[g+1]),
      .valid_o      (valid_w[g]),
      .entry_o      (entry_w[g])
    );
  end

  always_comb begin
    tok0_d = tok0_q;
    if (accept) begin
      tok0_d     = '0;
      tok0_d.vld = 1'b1;
    end else if (adv) begin
      tok0_d.vld = 1'b0;
    end
  end

  // token left the row unsettled: no free cell was found
  always_comb begin
    fin_status = last_tok.status;
    if (!last_tok.fin) begin
      case (item_q.func)
        FUNC_ADD:    fin_status = ST_FULL;
        FUNC_REMOVE: fin_status = ST_ABSENT;
        default:     fin_status = ST_DONE;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (exit_tok) begin
      if (item_q.func == FUNC_ADD && last_tok.fin && !last_tok.found) begin
        count_d = count_q + CNT_W'(1);
      end else if (item_q.func == FUNC_REMOVE && last_tok.found) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_d};

  always_comb begin
    out_d           = out_q;
    out_d.found     = last_tok.found;
    out_d.occupancy = occ_ext[OCC_W-1:0];
    out_d.empty_res = (count_d == '0);
    out_d.status    = fin_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tok0_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tok0_q  <= tok0_d;
      count_q <= count_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exit_tok) begin
        busy_q <= 1'b0;
      end
      if (exit_tok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (exit_tok) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_DEF(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `ASSERT_DEF(a_tok_busy, (tok0_q.vld || last_tok.vld) |-> busy_q, "token without item")
  `ASSERT_DEF(a_full_status, (out_valid_q && out_q.status == ST_FULL) |-> count_q == CNT_W'(CAPACITY), "full status on table with room")
  `ASSERT_DEF(a_empty_flag, out_valid_q |-> (out_q.empty_res == (count_q == '0)), "empty flag disagrees with count")

endmodule
